// ===== hw/rtl/pida_pkg.sv =====
`default_nettype none

package pida_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;

  // Widths fixed by the request and result fields
  localparam int OP_W    = 2;
  localparam int INDEX_W = 7;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pida_cell.sv =====
`default_nettype none

module pida_cell
  import pida_pkg::*;
#(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int IDX_W      = INDEX_W,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic [IDX_W-1:0]     pos,
  input  wire logic [WORD_BITS-1:0] word_new,
  input  wire logic [WORD_BITS-1:0] prev_word,
  input  wire logic [WORD_BITS-1:0] next_word,
  output logic      [WORD_BITS-1:0] slot,
  output logic      [WORD_BITS-1:0] tap
);

  localparam logic [IDX_W-1:0] HERE = IDX_W'(CELL_INDEX);

  // Insert: take the new word at pos, take the lower neighbor above pos.
  // Delete: take the upper neighbor at and above pos.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (HERE == pos) begin
        slot <= word_new;
      end else if (HERE > pos) begin
        slot <= prev_word;
      end
    end else if (ctrl.del && (HERE >= pos)) begin
      slot <= next_word;
    end
  end

  assign tap = (HERE == pos) ? slot : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_insert_delete_array_unit.sv =====
// Ordered list of non-zero words kept in a row of CAPACITY cells.
// Request channel: in_valid/in_stall with op, index and value. op selects
// append, insert at index, delete at index or read at index.
// Result channel: out_valid/out_stall with ok, data and count. One result
// per request, in request order; data is the word removed or read, zero
// otherwise; count is the number of entries after the request.
// The result is registered at the edge that accepts the request.
// Throughput is one request per cycle while in_stall is low, since every
// cell shifts toward or away from its neighbor in parallel at that edge.
// While a result waits under out_stall, in_stall is raised; a waiting
// result that is taken in the same cycle frees the register for the next
// request, so no bubble is added.
// Reset empties the list and drops any pending result; the cell contents
// are not cleared, and only entries below the count are ever read.
`default_nettype none

module positional_insert_delete_array_unit
  import pida_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    op,
  input  wire logic [INDEX_W-1:0] index,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    ok,
  output logic      [VALUE_W-1:0] data,
  output logic      [COUNT_W-1:0] count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic                 accept;
  op_t                  op_code;
  logic [WORD_BITS-1:0] word_in;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic [IDX_W-1:0]     cnt_ext;
  logic [IDX_W-1:0]     pos_ext;
  logic [IDX_W-1:0]     sel_pos;
  logic                 is_put;
  logic                 put_ok;
  logic                 take_ok;
  logic                 req_ok;
  logic                 full;
  cell_ctrl_t           ctrl;
  logic [WORD_BITS-1:0] sel_word;
  logic [VALUE_W-1:0]   data_next;

  logic [WORD_BITS-1:0] slot_q [CAPACITY];
  logic [WORD_BITS-1:0] taps   [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign op_code  = op_t'(op);
  assign word_in  = WORD_BITS'(value);
  assign cnt_ext  = IDX_W'(cnt);
  assign pos_ext  = IDX_W'(index);
  assign full     = (cnt == CNT_W'(CAPACITY));

  always_comb begin
    is_put  = 1'b0;
    sel_pos = pos_ext;
    req_ok  = 1'b0;
    unique case (op_code)
      OP_APPEND: begin
        is_put  = 1'b1;
        sel_pos = cnt_ext;
      end
      OP_INSERT: begin
        is_put  = 1'b1;
      end
      OP_DELETE,
      OP_READ: begin
        is_put  = 1'b0;
      end
      default: begin
        is_put  = 1'b0;
      end
    endcase
    put_ok  = (|word_in) && !full && (sel_pos <= cnt_ext);
    take_ok = pos_ext < cnt_ext;
    req_ok  = is_put ? put_ok : take_ok;
  end

  assign ctrl.ins = accept && is_put && put_ok;
  assign ctrl.del = accept && (op_code == OP_DELETE) && take_ok;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_BITS-1:0] prev_word;
      logic [WORD_BITS-1:0] next_word;

      if (g == 0) begin : g_first
        assign prev_word = '0;
      end else begin : g_mid_lo
        assign prev_word = slot_q[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign next_word = '0;
      end else begin : g_mid_hi
        assign next_word = slot_q[g+1];
      end

      pida_cell #(
        .WORD_BITS  (WORD_BITS),
        .IDX_W      (IDX_W),
        .CELL_INDEX (g)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .pos       (sel_pos),
        .word_new  (word_in),
        .prev_word (prev_word),
        .next_word (next_word),
        .slot      (slot_q[g]),
        .tap       (taps[g])
      );
    end
  endgenerate

  // At most one tap is non-zero; merge them
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_word = sel_word | taps[i];
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (ctrl.del) begin
      cnt_next = cnt - CNT_W'(1);
    end
    data_next = (req_ok && !is_put) ? VALUE_W'(sel_word) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok    <= req_ok;
      data  <= data_next;
      count <= COUNT_W'(cnt_next);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_del_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete in the same cycle");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.del |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cnt))
    else $error("count changed without a request");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (count == COUNT_W'(cnt)))
    else $error("result count does not match the list");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import pida_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] data;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op = OP_APPEND;
  logic [INDEX_W-1:0] index = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [VALUE_W-1:0] data;
  logic [COUNT_W-1:0] count;

  logic [VALUE_W-1:0] model_words[$];
  list_result_t       pending_results[$];
  int                 error_count = 0;
  int                 idle_cycles = 0;
  bit                 send_idle = 1'b0;
  bit                 recv_idle = 1'b0;
  bit                 hold_long = 1'b0;
  bit                 growing = 1'b1;

  positional_insert_delete_array_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .index     (index),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .data      (data),
    .count     (count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the list model and return the result it yields.
  function automatic list_result_t apply_list_op(op_t o, logic [INDEX_W-1:0] idx,
                                                 logic [VALUE_W-1:0] val);
    list_result_t r;
    int           fill;
    r = '0;
    fill = model_words.size();
    case (o)
      OP_APPEND: begin
        if (val != '0 && fill < LIST_CAP) begin
          model_words.push_back(val);
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (val != '0 && idx <= fill && fill < LIST_CAP) begin
          model_words.insert(idx, val);
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (idx < fill) begin
          r.data = model_words[idx];
          model_words.delete(idx);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (idx < fill) begin
          r.data = model_words[idx];
          r.ok = 1'b1;
        end
      end
    endcase
    r.count = COUNT_W'(model_words.size());
    return r;
  endfunction

  // Predict at the edge that accepts a request.
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall === 1'b0)
      pending_results.push_back(apply_list_op(op_t'(op), index, value));
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0b data=%h count=%0d",
                 $time, ok, data, count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) begin
          $display("%0t: ok mismatch, expected %0b, actual %0b", $time, want.ok, ok);
          error_count++;
        end
        if (data !== want.data) begin
          $display("%0t: data mismatch, expected %h, actual %h", $time, want.data, data);
          error_count++;
        end
        if (count !== want.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d",
                   $time, want.count, count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls if recv_idle, and one long hold if hold_long.
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Valid stays high after acceptance; an idle gap or drain_results lowers it.
  task automatic send_request(op_t o, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
    int gap;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    index    <= idx;
    value    <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(int fill);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return INDEX_W'($urandom_range(0, fill));
    if (r == 7) return INDEX_W'(fill);
    return INDEX_W'($urandom_range(0, 127));
  endfunction

  task automatic send_random_request();
    int  fill;
    int  r;
    op_t o;
    fill = model_words.size();
    // Swing the fill level between empty and full.
    if (fill >= LIST_CAP) growing = 1'b0;
    else if (fill <= 1) growing = 1'b1;
    r = $urandom_range(0, 99);
    if (growing)
      o = (r < 35) ? OP_APPEND : (r < 65) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_READ;
    else
      o = (r < 10) ? OP_APPEND : (r < 25) ? OP_INSERT : (r < 70) ? OP_DELETE : OP_READ;
    send_request(o, pick_index(fill), pick_value());
  endtask

  task automatic test_empty_list();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_request(OP_READ, '0, 32'h1234_5678);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_INSERT, INDEX_W'(1), 32'hDEAD_BEEF);
    send_request(OP_APPEND, '0, '0);
    send_request(OP_INSERT, '0, '0);
    drain_results();
  endtask

  task automatic test_basic_ops();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_request(OP_APPEND, INDEX_W'(127), 32'hFFFF_FFFF);
    send_request(OP_APPEND, '0, 32'h0000_0001);
    send_request(OP_INSERT, '0, 32'h8000_0000);
    send_request(OP_INSERT, INDEX_W'(3), 32'h5A5A_5A5A);
    send_request(OP_READ, '0, '0);
    send_request(OP_READ, INDEX_W'(3), '0);
    send_request(OP_READ, INDEX_W'(4), '1);
    send_request(OP_DELETE, INDEX_W'(1), '0);
    send_request(OP_DELETE, INDEX_W'(127), '0);
    send_request(OP_READ, INDEX_W'(127), '0);
    drain_results();
  endtask

  task automatic test_store_full();
    int n;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    n = LIST_CAP - model_words.size();
    repeat (n) send_request(OP_APPEND, '0, $urandom_range(1, 32'hFFFF_FFFF));
    send_request(OP_APPEND, '0, 32'h0BAD_0BAD);
    send_request(OP_INSERT, '0, 32'h0BAD_0BAD);
    send_request(OP_INSERT, INDEX_W'(LIST_CAP), 32'h0BAD_0BAD);
    send_request(OP_READ, INDEX_W'(LIST_CAP - 1), '0);
    send_request(OP_DELETE, INDEX_W'(LIST_CAP - 1), '0);
    send_request(OP_INSERT, '0, 32'hA5A5_A5A5);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_READ, INDEX_W'(LIST_CAP), '0);
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_long = 1'b1;
    repeat (20) send_random_request();
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 0) || (phase == 2);
      recv_idle = (phase == 0) || (phase == 3);
      repeat (112) send_random_request();
      drain_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_store_full();
    test_backpressure();
    test_random_traffic();
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
